>>> src/nrom_pkg.sv
`default_nettype none

package nrom_pkg;

   // Table geometry.
   localparam int NUM_PORTS    = 3;
   localparam int NUM_CHANNELS = 16;
   localparam int NUM_NOTES    = 128;
   localparam int ENTRY_COUNT  = NUM_PORTS * NUM_CHANNELS * NUM_NOTES;
   localparam int IDX_W        = $clog2(ENTRY_COUNT);
   localparam int PORT_STRIDE  = NUM_CHANNELS * NUM_NOTES;

   // Request queue between the front and the back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   // Reference count width and its saturation value.
   localparam int CNT_W = 16;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Request kinds.
   localparam logic KIND_ON  = 1'b0;
   localparam logic KIND_OFF = 1'b1;

   // One request as it travels from the front to the back.
   typedef struct packed {
      logic             kind;
      logic [1:0]       destination;
      logic [3:0]       channel;
      logic [6:0]       note;
      logic [6:0]       velocity;
      logic             accept_first;
      logic             accept_second;
      logic [IDX_W-1:0] idx;
   } req_type;

   // Queue fill status seen by the front.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Status of the back seen by the front.
   typedef struct packed {
      logic clearing;
   } back_status_type;

   // One table entry: pending-off mark and reference count.
   typedef struct packed {
      logic             pend;
      logic [CNT_W-1:0] count;
   } entry_type;

endpackage

`default_nettype wire

>>> src/nrom_queue.sv
`default_nettype none

module nrom_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire nrom_pkg::req_type     push_data,
   input  wire logic                  pop,
   output nrom_pkg::req_type          head_data,
   output nrom_pkg::q_status_type     status
);
   import nrom_pkg::*;

   req_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff;
   logic [Q_PTR_W-1:0]   wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff;
   logic [Q_PTR_W-1:0]   rd_ptr_in;
   logic [Q_PTR_W:0]     count_ff;
   logic [Q_PTR_W:0]     count_in;

   // Pointer and fill count updates; the front never pushes when full
   // and the back never pops when empty.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots carry payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data    = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == (Q_PTR_W + 1)'(Q_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

>>> src/nrom_front.sv
`default_nettype none

module nrom_front (
   input  wire logic                      start,
   input  wire logic                      req_kind,
   input  wire logic [1:0]                req_destination,
   input  wire logic [3:0]                req_channel,
   input  wire logic [6:0]                req_note,
   input  wire logic [6:0]                req_velocity,
   input  wire logic                      req_accept_first,
   input  wire logic                      req_accept_second,
   input  wire nrom_pkg::q_status_type    q_status,
   input  wire nrom_pkg::back_status_type back_status,
   output logic                           busy,
   output logic                           push,
   output nrom_pkg::req_type              push_data
);
   import nrom_pkg::*;

   logic accept;
   logic in_range;

   // The front holds off new requests while the table is being cleared
   // or while the queue has no free slot.
   assign busy   = back_status.clearing || q_status.full;
   assign accept = start && !busy;

   // Requests outside the table are dropped here and never reach the back.
   assign in_range = (32'(req_destination) < 32'(NUM_PORTS)) &&
                     (32'(req_channel) < 32'(NUM_CHANNELS)) &&
                     (32'(req_note) < 32'(NUM_NOTES));

   assign push = accept && in_range;

   // Build the queue entry with its flat table index.
   always_comb begin
      push_data.kind          = req_kind;
      push_data.destination   = req_destination;
      push_data.channel       = req_channel;
      push_data.note          = req_note;
      push_data.velocity      = req_velocity;
      push_data.accept_first  = req_accept_first;
      push_data.accept_second = req_accept_second;
      push_data.idx           = IDX_W'(req_destination) * IDX_W'(PORT_STRIDE) +
                                IDX_W'(req_channel) * IDX_W'(NUM_NOTES) +
                                IDX_W'(req_note);
   end

endmodule

`default_nettype wire

>>> src/nrom_back.sv
`default_nettype none

module nrom_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data,
   input  wire nrom_pkg::req_type     head_data,
   input  wire nrom_pkg::q_status_type q_status,
   output logic                       pop,
   output nrom_pkg::back_status_type  back_status,
   output logic                       rsp_strobe,
   output logic [7:0]                 rsp_header_byte,
   output logic [7:0]                 rsp_status_byte,
   output logic [6:0]                 rsp_note_number,
   output logic [6:0]                 rsp_velocity_out,
   output logic [1:0]                 rsp_port,
   output logic                       rsp_accepted,
   output logic                       rsp_last,
   output logic [31:0]                rsp_drop_count
);
   import nrom_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EVAL   = 2'd1;
   localparam logic [1:0] ST_SECOND = 2'd2;

   entry_type          table_mem [ENTRY_COUNT];
   entry_type          rdata_ff;
   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   entry_type          wr_data;

   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic               clearing_ff;
   logic [IDX_W-1:0]   clear_cnt_ff;
   logic               primary_ff;
   logic [31:0]        drop_ff;
   logic [31:0]        drop_in;
   req_type            item_ff;

   logic               strobe_ff;
   logic               strobe_in;
   logic [7:0]         header_ff;
   logic [7:0]         header_in;
   logic [7:0]         status_ff;
   logic [7:0]         status_in;
   logic [6:0]         note_ff;
   logic [6:0]         note_in;
   logic [6:0]         vel_ff;
   logic [6:0]         vel_in;
   logic [1:0]         port_ff;
   logic [1:0]         port_in;
   logic               acc_ff;
   logic               acc_in;
   logic               last_ff;
   logic               last_in;
   logic [31:0]        dcount_ff;
   logic [31:0]        dcount_in;

   logic               silent;
   entry_type          new_entry;
   logic               p0_valid;
   logic               p0_on;
   logic               p0_ok;
   logic               p1_valid;
   logic               on_ok;
   logic               off_ok;
   logic [31:0]        drop_mid;
   logic               cur_on;

   // Packet header: cable 0 for the internal port, 2 otherwise.
   function automatic logic [7:0] make_header(input logic is_on, input logic [1:0] dest);
      logic [3:0] cable;
      cable = (dest == 2'd2) ? 4'd0 : 4'd2;
      return {cable, (is_on ? 4'h9 : 4'h8)};
   endfunction

   function automatic logic [7:0] make_status(input logic is_on, input logic [3:0] ch);
      return {(is_on ? 4'h9 : 4'h8), ch};
   endfunction

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         primary_ff <= 1'b1;
      end else if (csr_wr_en) begin
         primary_ff <= csr_wr_data;
      end
   end

   // Clearing pass over the whole table after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clearing_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == IDX_W'(ENTRY_COUNT - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   assign back_status.clearing = clearing_ff;

   // Take the next request when idle; its table entry is read in the same cycle.
   assign pop   = (state_ff == ST_IDLE) && !clearing_ff && !q_status.empty;
   assign rd_en = pop;

   // Decide the packets and the entry update from the entry just read.
   always_comb begin
      silent    = (item_ff.destination == 2'd0) && !primary_ff;
      new_entry = rdata_ff;
      p0_valid  = 1'b0;
      p0_on     = 1'b0;
      p0_ok     = 1'b0;
      p1_valid  = 1'b0;
      on_ok     = 1'b0;
      off_ok    = 1'b0;
      if (item_ff.kind == KIND_ON) begin
         if (rdata_ff.pend) begin
            // Resend the refused off first, then try the on.
            off_ok   = silent || item_ff.accept_first;
            p0_valid = !silent;
            p0_ok    = item_ff.accept_first;
            if (off_ok) begin
               on_ok           = silent || item_ff.accept_second;
               p1_valid        = !silent;
               new_entry.pend  = 1'b0;
               new_entry.count = on_ok ? CNT_W'(1) : '0;
            end
         end else if (rdata_ff.count != '0) begin
            if (rdata_ff.count != CNT_MAX) begin
               new_entry.count = rdata_ff.count + 1'b1;
            end
         end else begin
            on_ok           = silent || item_ff.accept_first;
            p0_valid        = !silent;
            p0_on           = 1'b1;
            p0_ok           = item_ff.accept_first;
            new_entry.count = on_ok ? CNT_W'(1) : '0;
         end
      end else begin
         if (rdata_ff.count > CNT_W'(1)) begin
            new_entry.count = rdata_ff.count - 1'b1;
         end else if (rdata_ff.count == CNT_W'(1)) begin
            off_ok   = silent || item_ff.accept_first;
            p0_valid = !silent;
            p0_ok    = item_ff.accept_first;
            if (off_ok) begin
               new_entry.count = '0;
               new_entry.pend  = 1'b0;
            end else begin
               new_entry.pend = 1'b1;
            end
         end
      end
   end

   // Drop count after each emitted packet.
   assign drop_mid = drop_ff + ((p0_valid && !p0_ok) ? 32'd1 : 32'd0);

   // Sequencer and result register inputs.
   always_comb begin
      state_in  = state_ff;
      drop_in   = drop_ff;
      strobe_in = 1'b0;
      cur_on    = 1'b1;
      header_in = header_ff;
      status_in = status_ff;
      note_in   = note_ff;
      vel_in    = vel_ff;
      port_in   = port_ff;
      acc_in    = acc_ff;
      last_in   = last_ff;
      dcount_in = dcount_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cur_on    = p0_on;
            strobe_in = p0_valid;
            header_in = make_header(cur_on, item_ff.destination);
            status_in = make_status(cur_on, item_ff.channel);
            note_in   = item_ff.note;
            vel_in    = cur_on ? item_ff.velocity : 7'd0;
            port_in   = item_ff.destination;
            acc_in    = p0_ok;
            last_in   = !p1_valid;
            dcount_in = drop_mid;
            drop_in   = drop_mid + ((p1_valid && !item_ff.accept_second) ? 32'd1 : 32'd0);
            state_in  = p1_valid ? ST_SECOND : ST_IDLE;
         end
         ST_SECOND: begin
            // The second packet is always the on after a resent off.
            strobe_in = 1'b1;
            header_in = make_header(cur_on, item_ff.destination);
            status_in = make_status(cur_on, item_ff.channel);
            note_in   = item_ff.note;
            vel_in    = item_ff.velocity;
            port_in   = item_ff.destination;
            acc_in    = item_ff.accept_second;
            last_in   = 1'b1;
            dcount_in = drop_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         drop_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         drop_ff   <= drop_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head_data;
      end
      header_ff <= header_in;
      status_ff <= status_in;
      note_ff   <= note_in;
      vel_ff    <= vel_in;
      port_ff   <= port_in;
      acc_ff    <= acc_in;
      last_ff   <= last_in;
      dcount_ff <= dcount_in;
   end

   // Table write port: the clearing pass or the entry update.
   assign wr_en   = clearing_ff || (state_ff == ST_EVAL);
   assign wr_addr = clearing_ff ? clear_cnt_ff : item_ff.idx;
   assign wr_data = clearing_ff ? entry_type'('0) : new_entry;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= table_mem[head_data.idx];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_header_byte  = header_ff;
   assign rsp_status_byte  = status_ff;
   assign rsp_note_number  = note_ff;
   assign rsp_velocity_out = vel_ff;
   assign rsp_port         = port_ff;
   assign rsp_accepted     = acc_ff;
   assign rsp_last         = last_ff;
   assign rsp_drop_count   = dcount_ff;

endmodule

`default_nettype wire

>>> src/note_refcount_output_merger.sv
// Note reference-count output merger.
// A request (note on or off for one port, channel and note) is taken by a
// transfer at a rising edge with start high and busy low. The accept bits
// that come with it say whether the downstream link takes the first and
// second packet the request sends. Each request gives zero, one or two
// USB-MIDI packets on the rsp_ ports, each valid for exactly one cycle
// while rsp_strobe is high; the receiver cannot stall, so no result waits.
// rsp_last marks the final packet of a request.
// The first packet of a request passes the queue, the table read and the
// decide step before it shows up, a second one on the next cycle. The back
// takes a new request only when idle, after the packets of the last one,
// bounded by the read-modify-write of the entry table; a two-slot
// queue lets the front take requests ahead of it. busy is high while
// that queue is full.
// After reset the table is cleared one entry per cycle, all 6144 of them,
// with busy high. csr_wr_en/csr_wr_data set primary availability (reset 1) and
// are taken at any edge, but are meant to change only while idle.
`default_nettype none

module note_refcount_output_merger (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_kind,
   input  wire logic [1:0]  req_destination,
   input  wire logic [3:0]  req_channel,
   input  wire logic [6:0]  req_note,
   input  wire logic [6:0]  req_velocity,
   input  wire logic        req_accept_first,
   input  wire logic        req_accept_second,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data,
   output logic             rsp_strobe,
   output logic [7:0]       rsp_header_byte,
   output logic [7:0]       rsp_status_byte,
   output logic [6:0]       rsp_note_number,
   output logic [6:0]       rsp_velocity_out,
   output logic [1:0]       rsp_port,
   output logic             rsp_accepted,
   output logic             rsp_last,
   output logic [31:0]      rsp_drop_count
);
   import nrom_pkg::*;

   logic            push;
   req_type         push_data;
   logic            pop;
   req_type         head_data;
   q_status_type    q_status;
   back_status_type back_status;

   // Front: takes and classifies requests.
   nrom_front u_front (
      .start             (start),
      .req_kind          (req_kind),
      .req_destination   (req_destination),
      .req_channel       (req_channel),
      .req_note          (req_note),
      .req_velocity      (req_velocity),
      .req_accept_first  (req_accept_first),
      .req_accept_second (req_accept_second),
      .q_status          (q_status),
      .back_status       (back_status),
      .busy              (busy),
      .push              (push),
      .push_data         (push_data)
   );

   // Queue between front and back.
   nrom_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   // Back: table update and packet output.
   nrom_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .head_data        (head_data),
      .q_status         (q_status),
      .pop              (pop),
      .back_status      (back_status),
      .rsp_strobe       (rsp_strobe),
      .rsp_header_byte  (rsp_header_byte),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_note_number  (rsp_note_number),
      .rsp_velocity_out (rsp_velocity_out),
      .rsp_port         (rsp_port),
      .rsp_accepted     (rsp_accepted),
      .rsp_last         (rsp_last),
      .rsp_drop_count   (rsp_drop_count)
   );

endmodule

`default_nettype wire

>>> dv/note_refcount_output_merger_test.sv
module note_refcount_output_merger_test;
   timeunit 1ns;
   timeprecision 1ps;

   import nrom_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RESET_CYCLES   = 9;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int STACK_DEPTH    = 8;

   // Destinations, cables, USB-MIDI code indexes and status bytes.
   localparam logic [1:0] DEST_PRIMARY    = 2'd0;
   localparam logic [1:0] DEST_EXTERNAL   = 2'd1;
   localparam logic [1:0] DEST_INTERNAL   = 2'd2;
   localparam logic [1:0] DEST_UNUSED     = 2'd3;
   localparam logic [3:0] CABLE_INTERNAL  = 4'h0;
   localparam logic [3:0] CABLE_OTHER     = 4'h2;
   localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
   localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
   localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;

   typedef struct {
      logic       kind;
      logic [1:0] destination;
      logic [3:0] channel;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       accept_first;
      logic       accept_second;
   } note_request_type;

   typedef struct {
      logic [7:0]  header_byte;
      logic [7:0]  status_byte;
      logic [6:0]  note_number;
      logic [6:0]  velocity_out;
      logic [1:0]  port;
      logic        accepted;
      logic        last;
      logic [31:0] drop_count;
   } midi_packet_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_kind = KIND_ON;
   logic [1:0]  req_destination = DEST_PRIMARY;
   logic [3:0]  req_channel = '0;
   logic [6:0]  req_note = '0;
   logic [6:0]  req_velocity = '0;
   logic        req_accept_first = 1'b0;
   logic        req_accept_second = 1'b0;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        rsp_strobe;
   logic [7:0]  rsp_header_byte;
   logic [7:0]  rsp_status_byte;
   logic [6:0]  rsp_note_number;
   logic [6:0]  rsp_velocity_out;
   logic [1:0]  rsp_port;
   logic        rsp_accepted;
   logic        rsp_last;
   logic [31:0] rsp_drop_count;

   // Requests waiting to be offered, and packets the note table should send.
   note_request_type pending_reqs[$];
   midi_packet_type  expected_packets[$];
   midi_packet_type  request_packets[$];

   // Shadow of the note table, the drop counter and the primary link flag.
   bit [CNT_W-1:0] voice_count [ENTRY_COUNT];
   bit             off_pending_mark [ENTRY_COUNT];
   bit [31:0]      drop_total = '0;
   bit             primary_up = 1'b1;
   bit [1:0]       link_accepts;

   bit req_fired = 1'b0;
   int sender_idle_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   note_refcount_output_merger i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_destination   (req_destination),
      .req_channel       (req_channel),
      .req_note          (req_note),
      .req_velocity      (req_velocity),
      .req_accept_first  (req_accept_first),
      .req_accept_second (req_accept_second),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_header_byte   (rsp_header_byte),
      .rsp_status_byte   (rsp_status_byte),
      .rsp_note_number   (rsp_note_number),
      .rsp_velocity_out  (rsp_velocity_out),
      .rsp_port          (rsp_port),
      .rsp_accepted      (rsp_accepted),
      .rsp_last          (rsp_last),
      .rsp_drop_count    (rsp_drop_count)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // One packet attempt. Returns whether the link takes it.
   function automatic bit try_send(input logic [1:0] dest, input logic [3:0] cin,
                                   input logic [7:0] status, input logic [6:0] note,
                                   input logic [6:0] velocity);
      midi_packet_type pkt;
      // A missing primary link swallows the packet without using an accept bit.
      if (dest == DEST_PRIMARY && !primary_up) return 1'b1;
      pkt.accepted = link_accepts[request_packets.size()];
      if (!pkt.accepted) drop_total = drop_total + 1;
      pkt.header_byte  = {(dest == DEST_INTERNAL) ? CABLE_INTERNAL : CABLE_OTHER, cin};
      pkt.status_byte  = status;
      pkt.note_number  = note;
      pkt.velocity_out = velocity;
      pkt.port         = dest;
      pkt.last         = 1'b0;
      pkt.drop_count   = drop_total;
      request_packets.push_back(pkt);
      return pkt.accepted;
   endfunction

   // Update the shadow table for one request and queue the packets it sends.
   function automatic void predict_packets(input note_request_type r);
      int unsigned     idx;
      bit              go_on;
      midi_packet_type tail;
      request_packets.delete();
      link_accepts = {r.accept_second, r.accept_first};
      // Requests outside the table leave no trace.
      if (r.destination >= NUM_PORTS || r.channel >= NUM_CHANNELS || r.note >= NUM_NOTES)
         return;
      idx = (r.destination * NUM_CHANNELS + r.channel) * NUM_NOTES + r.note;

      if (r.kind == KIND_ON) begin
         go_on = 1'b1;
         // A refused off goes out first; if it is refused again the on is dropped.
         if (off_pending_mark[idx]) begin
            if (try_send(r.destination, CIN_NOTE_OFF, STATUS_NOTE_OFF | r.channel,
                         r.note, 7'd0)) begin
               off_pending_mark[idx] = 1'b0;
               voice_count[idx] = '0;
            end else begin
               go_on = 1'b0;
            end
         end
         if (go_on) begin
            if (voice_count[idx] != 0) begin
               if (voice_count[idx] != CNT_MAX) voice_count[idx]++;
            end else if (try_send(r.destination, CIN_NOTE_ON, STATUS_NOTE_ON | r.channel,
                                  r.note, r.velocity)) begin
               voice_count[idx] = CNT_W'(1);
            end
         end
      end else begin
         if (voice_count[idx] > 1) begin
            voice_count[idx]--;
         end else if (voice_count[idx] == 1) begin
            if (try_send(r.destination, CIN_NOTE_OFF, STATUS_NOTE_OFF | r.channel,
                         r.note, 7'd0)) begin
               voice_count[idx] = '0;
               off_pending_mark[idx] = 1'b0;
            end else begin
               off_pending_mark[idx] = 1'b1;
            end
         end
      end

      if (request_packets.size() != 0) begin
         tail = request_packets.pop_back();
         tail.last = 1'b1;
         request_packets.push_back(tail);
      end
      foreach (request_packets[i]) expected_packets.push_back(request_packets[i]);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Driver: offer the next pending request, idling at random between transfers.
   always @(negedge clock) begin : drive_requests
      note_request_type next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_fired) begin
         if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
            next_req = pending_reqs.pop_front();
            req_kind          <= next_req.kind;
            req_destination   <= next_req.destination;
            req_channel       <= next_req.channel;
            req_note          <= next_req.note;
            req_velocity      <= next_req.velocity;
            req_accept_first  <= next_req.accept_first;
            req_accept_second <= next_req.accept_second;
            start             <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check result transfers, predict for request transfers, watch for a hang.
   always @(posedge clock) begin : watch_transfers
      midi_packet_type  want;
      note_request_type offered;
      if (reset) begin
         req_fired = 1'b0;
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) primary_up = csr_wr_data;

         if (rsp_strobe) begin
            if (expected_packets.size() == 0) begin
               $display("%0t: packet with none expected, actual header %0h status %0h note %0h",
                        $time, rsp_header_byte, rsp_status_byte, rsp_note_number);
               mismatch_count++;
            end else begin
               want = expected_packets.pop_front();
               check_field("header_byte", 32'(want.header_byte), 32'(rsp_header_byte));
               check_field("status_byte", 32'(want.status_byte), 32'(rsp_status_byte));
               check_field("note_number", 32'(want.note_number), 32'(rsp_note_number));
               check_field("velocity_out", 32'(want.velocity_out),
                           32'(rsp_velocity_out));
               check_field("port", 32'(want.port), 32'(rsp_port));
               check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("drop_count", want.drop_count, rsp_drop_count);
            end
         end

         req_fired = start && !busy;
         if (req_fired) begin
            offered = '{req_kind, req_destination, req_channel, req_note, req_velocity,
                        req_accept_first, req_accept_second};
            predict_packets(offered);
         end

         if (req_fired || rsp_strobe) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("note_refcount_output_merger test failed");
            $finish;
         end
      end
   end

   task automatic queue_request(input logic kind, input logic [1:0] dest,
                                input logic [3:0] channel, input logic [6:0] note,
                                input logic [6:0] velocity, input logic first_ok,
                                input logic second_ok);
      pending_reqs.push_back('{kind, dest, channel, note, velocity, first_ok, second_ok});
   endtask

   // Random traffic, mostly aimed at a few busy entries so voices stack,
   // get refused and get resent.
   task automatic queue_random_requests(input int count);
      logic [1:0]       hot_dest [4];
      logic [3:0]       hot_channel [4];
      logic [6:0]       hot_note [4];
      int               pick;
      note_request_type r;
      foreach (hot_dest[i]) begin
         hot_dest[i]    = 2'($urandom_range(2, 0));
         hot_channel[i] = 4'($urandom_range(15, 0));
         hot_note[i]    = 7'($urandom_range(127, 0));
      end
      repeat (count) begin
         if ($urandom_range(3, 0) != 0) begin
            pick = $urandom_range(3, 0);
            r.destination = hot_dest[pick];
            r.channel     = hot_channel[pick];
            r.note        = hot_note[pick];
         end else begin
            r.destination = 2'($urandom_range(3, 0));
            r.channel     = 4'($urandom_range(15, 0));
            r.note        = 7'($urandom_range(127, 0));
         end
         r.kind          = $urandom_range(1, 0) ? KIND_OFF : KIND_ON;
         r.velocity      = 7'($urandom_range(127, 0));
         r.accept_first  = ($urandom_range(9, 0) < 8);
         r.accept_second = ($urandom_range(9, 0) < 8);
         pending_reqs.push_back(r);
      end
   endtask

   // Hold off until every request is taken and every packet has come out.
   task automatic wait_until_idle();
      while (pending_reqs.size() != 0 || start || expected_packets.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_primary_available(input logic value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Test sequence.
   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed: stacking, refused offs and their resend, ports and field extremes.
      sender_idle_pct = 0;
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd0, 7'd0, 7'd0, 1'b1, 1'b1);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd0, 7'd0, 7'd127, 1'b1, 1'b1);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd0, 7'd0, 7'd0, 1'b1, 1'b1);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd0, 7'd0, 7'd0, 1'b0, 1'b1);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd0, 7'd0, 7'd64, 1'b1, 1'b1);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd0, 7'd0, 7'd0, 1'b0, 1'b0);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd0, 7'd0, 7'd0, 1'b1, 1'b0);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd0, 7'd0, 7'd33, 1'b1, 1'b1);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd0, 7'd0, 7'd0, 1'b0, 1'b1);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd0, 7'd0, 7'd9, 1'b0, 1'b1);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd0, 7'd0, 7'd1, 1'b1, 1'b0);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd0, 7'd0, 7'd0, 1'b1, 1'b1);
      queue_request(KIND_ON,  DEST_UNUSED, 4'd15, 7'd127, 7'd127, 1'b1, 1'b1);
      queue_request(KIND_ON,  DEST_INTERNAL, 4'd15, 7'd127, 7'd127, 1'b1, 1'b1);
      queue_request(KIND_OFF, DEST_INTERNAL, 4'd15, 7'd127, 7'd85, 1'b1, 1'b1);
      queue_request(KIND_ON,  DEST_EXTERNAL, 4'd8, 7'd64, 7'd42, 1'b0, 1'b0);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd1, 7'd2, 7'd10, 1'b1, 1'b1);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd1, 7'd2, 7'd0, 1'b0, 1'b1);
      wait_until_idle();

      // Primary link down: its packets vanish and use no accept bit.
      write_primary_available(1'b0);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd1, 7'd2, 7'd11, 1'b0, 1'b0);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd1, 7'd2, 7'd0, 1'b0, 1'b0);
      queue_request(KIND_ON,  DEST_PRIMARY, 4'd3, 7'd5, 7'd20, 1'b0, 1'b1);
      queue_request(KIND_ON,  DEST_EXTERNAL, 4'd2, 7'd9, 7'd5, 1'b1, 1'b0);
      queue_request(KIND_OFF, DEST_PRIMARY, 4'd3, 7'd5, 7'd0, 1'b0, 1'b0);
      wait_until_idle();
      write_primary_available(1'b1);

      // Stack several voices on one entry, then unwind them; only the
      // last off may send a packet.
      queue_request(KIND_ON, DEST_EXTERNAL, 4'd5, 7'd60, 7'd100, 1'b1, 1'b1);
      repeat (STACK_DEPTH)
         queue_request(KIND_ON, DEST_EXTERNAL, 4'd5, 7'd60, 7'd100, 1'b1, 1'b1);
      repeat (STACK_DEPTH + 1)
         queue_request(KIND_OFF, DEST_EXTERNAL, 4'd5, 7'd60, 7'd0, 1'b1, 1'b1);
      wait_until_idle();

      // Random traffic in three phases of sender idling and link availability.
      sender_idle_pct = 37;
      queue_random_requests(450);
      wait_until_idle();
      write_primary_available(1'b0);
      sender_idle_pct = 55;
      queue_random_requests(450);
      wait_until_idle();
      write_primary_available(1'b1);
      sender_idle_pct = 0;
      queue_random_requests(500);
      wait_until_idle();

      if (mismatch_count == 0) begin
         $display("note_refcount_output_merger test passed");
      end else begin
         $display("note_refcount_output_merger test failed");
      end
      $finish;
   end

endmodule
